>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each check is sampled on the rising edge of aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that holds in the same cycle.
`define AST_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a property that holds in the following cycle.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ppfib_pkg.sv
package ppfib_pkg;

    // Default sizing
    localparam int PLAYERS_DEF = 8;
    localparam int ENTRIES_DEF = 16;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int PID_W    = 8;
    localparam int FRAME_W  = 16;
    localparam int BITS_W   = 16;
    localparam int S_DATA_W = PID_W + FRAME_W + BITS_W;
    localparam int M_DATA_W = BITS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_STORE  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic do_store;
        logic do_clear;
        logic look_start;
        logic scan_en;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic store_ok;
        logic look_empty;
        logic scan_done;
        logic out_free;
    } ctrl_status_t;

endpackage

>>> hdl/per_player_frame_input_buffer.sv
// Per-player frame input buffer.
// Slave stream carries commands: tuser holds the opcode (store, lookup, clear),
// tdata holds player id, frame number and controller bits. Master stream returns
// one item per lookup: tuser is the found flag, tdata the controller bits
// (zero if none). The local player id is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while idle, which the block does not enforce.
// Store and clear produce no result; a store for the local player or for an
// id of PLAYERS or above is dropped.
// A lookup reads the player's ring one record per cycle from the single
// memory read port, stopping at the first exact frame match; without one the
// result is the record with the largest frame, the earliest read on ties. An
// empty ring or an unknown player skips the scan. The next item is taken
// only after the result is loaded, so a lookup holds the input until then.
// A result waits in the output register while m_tready is low; stores and
// clears are still accepted then, and a following lookup holds its result
// until the register frees.
// Reset (aresetn low, synchronous) empties every ring, zeroes the write
// pointers and the local player id; valid records are tracked by
// per-player fill counts, so no clearing pass is needed.
`include "assert_macros.svh"

module per_player_frame_input_buffer #(
    parameter int PLAYERS            = ppfib_pkg::PLAYERS_DEF,
    parameter int ENTRIES_PER_PLAYER = ppfib_pkg::ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ppfib_pkg::PID_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // player [7:0], frame [23:8], controls [39:24]
    input  logic [ppfib_pkg::S_DATA_W-1:0] s_tdata,
    // opcode [1:0]
    input  logic [ppfib_pkg::OPCODE_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result controls [15:0]
    output logic [ppfib_pkg::M_DATA_W-1:0] m_tdata,
    // found [0]
    output logic                           m_tuser
);
    import ppfib_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    ppfib_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    ppfib_dpath #(
        .PLAYERS (PLAYERS),
        .ENTRIES (ENTRIES_PER_PLAYER)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // A lookup holds off intake until its result is loaded
    `AST_NEXT(a_lookup_blocks, s_tvalid && s_tready && (s_tuser == OP_LOOKUP), !s_tready, "intake open right after lookup")
    // Store and clear leave intake open
    `AST_NEXT(a_store_clear_fast, s_tvalid && s_tready && ((s_tuser == OP_STORE) || (s_tuser == OP_CLEAR)), s_tready, "intake closed after store or clear")
    // Never overwrite a result that is still waiting
    `AST_SAME(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "result overwritten while stalled")
    // At most one command per cycle
    `AST_SAME(a_one_cmd, 1'b1, $onehot0({cmd.do_store, cmd.do_clear, cmd.look_start, cmd.scan_en, cmd.load_out}), "conflicting commands")

endmodule

>>> hdl/ppfib_ctrl.sv
module ppfib_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ppfib_pkg::OPCODE_W-1:0] s_tuser,
    input  ppfib_pkg::ctrl_status_t       status,
    output ppfib_pkg::ctrl_cmd_t          cmd
);
    import ppfib_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (opcode_t'(s_tuser))
                        OP_STORE: begin
                            cmd.do_store = status.store_ok;
                        end
                        OP_CLEAR: begin
                            cmd.do_clear = 1'b1;
                        end
                        OP_LOOKUP: begin
                            cmd.look_start = 1'b1;
                            state_next = status.look_empty ? ST_RESULT : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ppfib_dpath.sv
module ppfib_dpath #(
    parameter int PLAYERS = ppfib_pkg::PLAYERS_DEF,
    parameter int ENTRIES = ppfib_pkg::ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ppfib_pkg::PID_W-1:0]    cfg_wr_data,
    input  logic [ppfib_pkg::S_DATA_W-1:0] s_tdata,
    input  ppfib_pkg::ctrl_cmd_t           cmd,
    output ppfib_pkg::ctrl_status_t        status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppfib_pkg::M_DATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import ppfib_pkg::*;

    localparam int PIX_W     = $clog2(PLAYERS);
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int MEM_DEPTH = 2 ** (PIX_W + IDX_W);
    localparam int REC_W     = FRAME_W + BITS_W;
    localparam logic [PID_W:0]   PID_LIMIT = (PID_W + 1)'(PLAYERS);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);

    // Input item fields
    logic [PID_W-1:0]   s_pid;
    logic [FRAME_W-1:0] s_frame;
    logic [BITS_W-1:0]  s_bits;
    logic [PIX_W-1:0]   s_pix;
    logic               pid_ok;

    assign s_pid   = s_tdata[PID_W-1:0];
    assign s_frame = s_tdata[PID_W +: FRAME_W];
    assign s_bits  = s_tdata[PID_W+FRAME_W +: BITS_W];
    assign s_pix   = s_pid[PIX_W-1:0];
    assign pid_ok  = {1'b0, s_pid} < PID_LIMIT;

    logic [PID_W-1:0] local_id_reg;

    // Per-player ring state: write pointer and fill count
    logic [IDX_W-1:0] wp_reg   [PLAYERS];
    logic [CNT_W-1:0] fill_reg [PLAYERS];

    // Record memory: frame in the upper half, bits in the lower
    logic [REC_W-1:0] mem [MEM_DEPTH];

    // Lookup scan state
    logic [PIX_W-1:0]   look_pix_reg;
    logic [FRAME_W-1:0] look_frame_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   iss_reg;
    logic [CNT_W-1:0]   ev_reg;
    logic               rd_vld_reg;
    logic [REC_W-1:0]   rd_data_reg;
    logic               have_reg;
    logic [FRAME_W-1:0] top_frame_reg;
    logic [BITS_W-1:0]  best_bits_reg;

    // Result register
    logic               m_tvalid_reg;
    logic               m_found_reg;
    logic [BITS_W-1:0]  m_bits_reg;

    logic               issue;
    logic               eval;
    logic [FRAME_W-1:0] rd_frame;
    logic [BITS_W-1:0]  rd_bits;
    logic               match;
    logic               look_last;

    assign issue     = cmd.scan_en && (iss_reg < cnt_reg);
    assign eval      = cmd.scan_en && rd_vld_reg;
    assign rd_frame  = rd_data_reg[BITS_W +: FRAME_W];
    assign rd_bits   = rd_data_reg[BITS_W-1:0];
    assign match     = rd_frame == look_frame_reg;
    assign look_last = ev_reg == (cnt_reg - CNT_W'(1));

    // Status toward the controller
    always_comb begin
        status.store_ok   = pid_ok && (s_pid != local_id_reg);
        status.look_empty = !pid_ok || (fill_reg[s_pix] == '0);
        status.scan_done  = eval && (match || look_last);
        status.out_free   = !m_tvalid_reg || m_tready;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_id_reg <= '0;
        end else if (cfg_wr_en) begin
            local_id_reg <= cfg_wr_data;
        end
    end

    // Advance the write pointer and fill count, reset all on clear
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.do_clear) begin
            for (int p = 0; p < PLAYERS; p++) begin
                wp_reg[p]   <= '0;
                fill_reg[p] <= '0;
            end
        end else if (cmd.do_store) begin
            wp_reg[s_pix] <= (wp_reg[s_pix] == IDX_LAST) ? '0 : wp_reg[s_pix] + IDX_W'(1);
            if (fill_reg[s_pix] != CNT_FULL) begin
                fill_reg[s_pix] <= fill_reg[s_pix] + CNT_W'(1);
            end
        end
    end

    // Record memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.do_store) begin
            mem[{s_pix, wp_reg[s_pix]}] <= {s_frame, s_bits};
        end
        if (issue) begin
            rd_data_reg <= mem[{look_pix_reg, iss_reg[IDX_W-1:0]}];
        end
    end

    // Read-valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
        end
    end

    // Latch the lookup, then issue reads and track the best record
    always_ff @(posedge aclk) begin
        if (cmd.look_start) begin
            look_pix_reg   <= s_pix;
            look_frame_reg <= s_frame;
            cnt_reg        <= pid_ok ? fill_reg[s_pix] : '0;
            iss_reg        <= '0;
            ev_reg         <= '0;
            have_reg       <= 1'b0;
            top_frame_reg  <= '0;
            best_bits_reg  <= '0;
        end else begin
            if (issue) begin
                iss_reg <= iss_reg + CNT_W'(1);
            end
            if (eval) begin
                ev_reg <= ev_reg + CNT_W'(1);
                if (match) begin
                    have_reg      <= 1'b1;
                    best_bits_reg <= rd_bits;
                end else if (!have_reg || (rd_frame > top_frame_reg)) begin
                    have_reg      <= 1'b1;
                    top_frame_reg <= rd_frame;
                    best_bits_reg <= rd_bits;
                end
            end
        end
    end

    // Output register: load the result, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_found_reg <= have_reg;
            m_bits_reg  <= best_bits_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_bits_reg;
    assign m_tuser  = m_found_reg;

endmodule

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppfib_pkg::*;

    localparam int PLAYERS = PLAYERS_DEF;
    localparam int ENTRIES = ENTRIES_DEF;
    // Longest lookup plus margin, used to let the block settle
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic        found;
        logic [15:0] bits;
    } reply_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [PID_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic [OPCODE_W-1:0] s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    // Shadow copy of the block state
    logic [15:0] ring_frame [PLAYERS][ENTRIES];
    logic [15:0] ring_bits  [PLAYERS][ENTRIES];
    bit          ring_valid [PLAYERS][ENTRIES];
    int          ring_wr    [PLAYERS];
    logic [7:0]  local_id = 8'd0;

    reply_t      expected_replies[$];
    int          errors = 0;

    // Sender and receiver pacing
    bit          tx_gaps = 1'b0;
    int          burst_left = 0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          hold_request = 0;
    logic [15:0] frame_cursor [PLAYERS];

    per_player_frame_input_buffer #(
        .PLAYERS            (PLAYERS),
        .ENTRIES_PER_PLAYER (ENTRIES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("per_player_frame_input_buffer verification failed");
        $finish;
    end

    // Invalidate every record and rewind the write pointers
    function automatic void clear_rings();
        foreach (ring_valid[p, e]) ring_valid[p][e] = 1'b0;
        foreach (ring_wr[p]) ring_wr[p] = 0;
    endfunction

    // Update the shadow state for one accepted item and queue the reply of a lookup
    function automatic void apply_command(input logic [OPCODE_W-1:0] op,
                                          input logic [7:0] pid,
                                          input logic [15:0] frame,
                                          input logic [15:0] bits);
        reply_t      r;
        int          slot;
        bit          have;
        bit          exact;
        logic [15:0] top_frame;
        r.found = 1'b0;
        r.bits = '0;
        have = 1'b0;
        exact = 1'b0;
        top_frame = '0;
        case (op)
            OP_STORE: begin
                if (pid != local_id && pid < PLAYERS) begin
                    slot = ring_wr[pid];
                    ring_frame[pid][slot] = frame;
                    ring_bits[pid][slot] = bits;
                    ring_valid[pid][slot] = 1'b1;
                    ring_wr[pid] = (slot + 1) % ENTRIES;
                end
            end
            OP_LOOKUP: begin
                if (pid < PLAYERS) begin
                    // First exact match wins, else the largest frame, earliest on ties
                    for (int i = 0; i < ENTRIES && !exact; i++) begin
                        if (ring_valid[pid][i]) begin
                            if (ring_frame[pid][i] == frame) begin
                                exact = 1'b1;
                                r.found = 1'b1;
                                r.bits = ring_bits[pid][i];
                            end else if (!have || ring_frame[pid][i] > top_frame) begin
                                have = 1'b1;
                                top_frame = ring_frame[pid][i];
                                r.found = 1'b1;
                                r.bits = ring_bits[pid][i];
                            end
                        end
                    end
                end
                expected_replies.push_back(r);
            end
            OP_CLEAR: clear_rings();
            default: ;
        endcase
    endfunction

    // Drive one item, wait for its handshake and predict its effect
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [7:0] pid,
                             input logic [15:0] frame, input logic [15:0] bits);
        if (tx_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {bits, frame, pid};
        do @(posedge aclk); while (!s_tready);
        apply_command(op, pid, frame, bits);
    endtask

    task automatic sender_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Hold the sender until every reply is in, then let the block settle
    task automatic wait_drained();
        sender_idle();
        while (expected_replies.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_local_id(input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        local_id = value;
    endtask

    // Receiver: long hold-offs on request, otherwise the selected stall pattern
    initial begin : receiver
        int hold_left;
        int rx_phase;
        hold_left = 0;
        rx_phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN: m_tready <= ((rx_phase % 7) < 4);
                    default:    m_tready <= 1'b1;
                endcase
                rx_phase++;
            end
        end
    end

    // Compare each reply with the oldest prediction
    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply found=%0b bits=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.found) begin
                    $display("%0t: found mismatch expected %0b actual %0b",
                             $time, want.found, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.bits) begin
                    $display("%0t: result bits mismatch expected %h actual %h",
                             $time, want.bits, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Empty rings, out-of-range and local players, exact match vs larger
    // frame, ties, field extremes, unused opcode and clear
    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        send_item(OP_LOOKUP, 8'd1, 16'd0, 16'hFFFF);
        send_item(OP_LOOKUP, 8'd8, 16'd0, 16'd0);
        send_item(OP_LOOKUP, 8'd255, 16'hFFFF, 16'd0);
        send_item(OP_STORE, 8'd0, 16'd10, 16'hBEEF);
        send_item(OP_LOOKUP, 8'd0, 16'd10, 16'd0);
        send_item(OP_STORE, 8'd8, 16'd10, 16'h1111);
        send_item(OP_STORE, 8'd255, 16'd10, 16'h2222);
        send_item(OP_STORE, 8'd1, 16'd100, 16'h0001);
        send_item(OP_STORE, 8'd1, 16'hFFFF, 16'hFFFF);
        send_item(OP_STORE, 8'd1, 16'd0, 16'h0000);
        send_item(OP_STORE, 8'd1, 16'hFFFF, 16'hAAAA);
        send_item(OP_STORE, 8'd1, 16'd50, 16'h5555);
        send_item(OP_LOOKUP, 8'd1, 16'd50, 16'd0);
        send_item(OP_LOOKUP, 8'd1, 16'd7, 16'd0);
        send_item(OP_LOOKUP, 8'd1, 16'd0, 16'd0);
        send_item(OP_UNUSED, 8'd1, 16'd7, 16'h1234);
        send_item(OP_LOOKUP, 8'd1, 16'd7, 16'd0);
        send_item(OP_STORE, 8'd7, 16'hFFFF, 16'h1234);
        send_item(OP_LOOKUP, 8'd7, 16'd0, 16'd0);
        send_item(OP_CLEAR, 8'd0, 16'd0, 16'd0);
        send_item(OP_LOOKUP, 8'd1, 16'd50, 16'd0);
        send_item(OP_LOOKUP, 8'd7, 16'hFFFF, 16'd0);
        wait_drained();
    endtask

    // Move the local player id through its extremes; its stores must vanish
    task automatic test_local_id();
        logic [7:0] ids [4];
        ids = '{8'd255, 8'd7, 8'd3, 8'd0};
        foreach (ids[k]) begin
            write_local_id(ids[k]);
            send_item(OP_STORE, ids[k], 16'd42, 16'hC0DE);
            send_item(OP_STORE, (ids[k] + 8'd1) & 8'd7, 16'd42, 16'hF00D);
            send_item(OP_LOOKUP, ids[k], 16'd42, 16'd0);
            send_item(OP_LOOKUP, (ids[k] + 8'd1) & 8'd7, 16'd42, 16'd0);
            wait_drained();
        end
    endtask

    // Produce one random item, mostly stores and lookups near each player's frame
    task automatic random_item();
        int          r;
        logic [7:0]  pid;
        logic [15:0] frame;
        r = $urandom_range(0, 999);
        pid = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, PLAYERS - 1))
                                          : 8'($urandom_range(PLAYERS, 255));
        if (r < 470) begin
            if ($urandom_range(0, 9) == 0) begin
                frame = 16'($urandom);
            end else begin
                frame = frame_cursor[pid % PLAYERS] + 16'($urandom_range(0, 3));
                frame_cursor[pid % PLAYERS] = frame;
            end
            send_item(OP_STORE, pid, frame, 16'($urandom));
        end else if (r < 960) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: frame = frame_cursor[pid % PLAYERS] - 16'($urandom_range(0, 20));
                5, 6, 7:       frame = 16'($urandom);
                default:       frame = frame_cursor[pid % PLAYERS] + 16'($urandom_range(1, 5));
            endcase
            send_item(OP_LOOKUP, pid, frame, 16'($urandom));
        end else if (r < 985) begin
            send_item(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            send_item(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // Random phases with varying local id and pacing
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            write_local_id((phase == 3) ? 8'd255 : 8'($urandom_range(0, PLAYERS - 1)));
            foreach (frame_cursor[p])
                frame_cursor[p] = ($urandom_range(0, 3) == 0) ? 16'hFFF0 : 16'($urandom);
            tx_gaps = (phase != 0);
            rx_mode = (phase == 0) ? RX_ALWAYS : (phase == 1) ? RX_PATTERN : RX_RANDOM;
            for (int n = 0; n < 80; n++) begin
                random_item();
                if (n % 40 == 39) wait_drained();
            end
            wait_drained();
        end
    endtask

    // Stall the receiver for a long stretch while lookups keep coming
    task automatic test_backpressure();
        write_local_id(8'd0);
        tx_gaps = 1'b0;
        rx_mode = RX_RANDOM;
        for (int n = 0; n < 10; n++)
            send_item(OP_STORE, 8'($urandom_range(1, PLAYERS - 1)), 16'($urandom), 16'($urandom));
        hold_request = 300;
        for (int n = 0; n < 30; n++) begin
            if (n % 3 == 2)
                send_item(OP_STORE, 8'($urandom_range(0, PLAYERS - 1)), 16'($urandom),
                          16'($urandom));
            else
                send_item(OP_LOOKUP, 8'($urandom_range(0, PLAYERS - 1)), 16'($urandom),
                          16'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        clear_rings();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_local_id();
        test_backpressure();
        test_random();
        wait_drained();
        if (errors == 0) begin
            $display("per_player_frame_input_buffer verification clean");
        end else begin
            $display("per_player_frame_input_buffer verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/ppfib_pkg.sv
hdl/ppfib_ctrl.sv
hdl/ppfib_dpath.sv
hdl/per_player_frame_input_buffer.sv
sim/tb_top.sv
